// ----- sv/cde_pkg.sv -----
// shared constants, codes and control/status types for the circular deque engine
// no dependencies
package cde_pkg;

   localparam int DEPTH       = 16;
   localparam int DATA_W      = 32;
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int FUNC_W      = 4;
   localparam int INDEX_W     = 4;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd0;
   localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd1;
   localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd2;
   localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd3;
   localparam logic [FUNC_W-1:0] FN_PEEK_FRONT = 4'd4;
   localparam logic [FUNC_W-1:0] FN_PEEK_BACK  = 4'd5;
   localparam logic [FUNC_W-1:0] FN_GET        = 4'd6;
   localparam logic [FUNC_W-1:0] FN_REMOVE     = 4'd7;
   localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd8;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   localparam logic [1:0] RD_HEAD  = 2'd0;
   localparam logic [1:0] RD_TAIL  = 2'd1;
   localparam logic [1:0] RD_INDEX = 2'd2;
   localparam logic [1:0] RD_NEXT  = 2'd3;

   localparam logic [1:0] WR_FRONT = 2'd0;
   localparam logic [1:0] WR_BACK  = 2'd1;
   localparam logic [1:0] WR_ITER  = 2'd2;

   typedef struct packed {
      logic                latch;
      logic                rd_en;
      logic [1:0]          rd_sel;
      logic                wr_en;
      logic [1:0]          wr_sel;
      logic                head_dec;
      logic                head_inc;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                clear;
      logic                iter_load;
      logic                iter_inc;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
      logic                rsp_use_rd;
   } cde_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              empty;
      logic              full;
      logic              idx_ok;
      logic              shift_more;
      logic              rsp_busy;
   } cde_stat_type;

endpackage

// ----- sv/circular_deque_engine_top.sv -----
// circular deque engine top level: controller plus datapath
// flow: a word is taken, executed, and its result loaded into the result register once that is free
// no new request is taken until the previous result is loaded; remove shifts each element after
// index toward the head, by a read then a write of the element store per shifted element
// reset: synchronous active high, empties the deque; store contents are not cleared
// depends on cde_pkg, cde_ctrl, cde_dp
module circular_deque_engine_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cde_pkg::REQ_TDATA_W-1:0] req_tdata,   // func, data_in, index
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cde_pkg::RSP_TDATA_W-1:0] rsp_tdata    // data_out, status, count, zero pad
);

   cde_pkg::cde_cmd_type  cmd;
   cde_pkg::cde_stat_type stat;

   cde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cde_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTH
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in flight");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !stat.rsp_busy)
      else $error("result register overwritten while stalled");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[33:32] == cde_pkg::ST_FULL)
      |-> (rsp_tdata[38:34] == cde_pkg::CNT_W'(cde_pkg::DEPTH)))
      else $error("full status with count below capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[33:32] == cde_pkg::ST_EMPTY)
      |-> (rsp_tdata[38:34] == '0 && rsp_tdata[31:0] == '0))
      else $error("empty status with live elements or data");
`endif

endmodule

// ----- sv/cde_dp.sv -----
// deque datapath: element store, head pointer, count, shift iterator and result register
// depends on cde_pkg
module cde_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [cde_pkg::REQ_TDATA_W-1:0] req_tdata,   // func, data_in, index
   input  cde_pkg::cde_cmd_type            cmd,
   output cde_pkg::cde_stat_type           stat,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cde_pkg::RSP_TDATA_W-1:0] rsp_tdata    // data_out, status, count, zero pad
);

   logic [cde_pkg::DATA_W-1:0]   mem [cde_pkg::DEPTH];

   logic [cde_pkg::FUNC_W-1:0]   func_ff;
   logic [cde_pkg::DATA_W-1:0]   data_ff;
   logic [cde_pkg::INDEX_W-1:0]  index_ff;
   logic [cde_pkg::PTR_W-1:0]    head_ff, head_in;
   logic [cde_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [cde_pkg::PTR_W-1:0]    iter_ff;
   logic [cde_pkg::DATA_W-1:0]   rd_data_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cde_pkg::DATA_W-1:0]   rsp_data_ff;
   logic [cde_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [cde_pkg::CNT_W-1:0]    rsp_count_ff;

   logic [cde_pkg::PTR_W-1:0]    cnt_lo;
   logic [cde_pkg::PTR_W-1:0]    rd_addr, wr_addr;
   logic [cde_pkg::DATA_W-1:0]   wr_data;
   logic [cde_pkg::CNT_W-1:0]    iter_next;

   assign cnt_lo    = cnt_ff[cde_pkg::PTR_W-1:0];
   assign iter_next = {1'b0, iter_ff} + cde_pkg::CNT_W'(1);

   always_comb begin
      case (cmd.rd_sel)
         cde_pkg::RD_HEAD:  rd_addr = head_ff;
         cde_pkg::RD_TAIL:  rd_addr = head_ff + cnt_lo - cde_pkg::PTR_W'(1);
         cde_pkg::RD_INDEX: rd_addr = head_ff + cde_pkg::PTR_W'(index_ff);
         cde_pkg::RD_NEXT:  rd_addr = head_ff + iter_ff + cde_pkg::PTR_W'(1);
         default:           rd_addr = head_ff;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         cde_pkg::WR_FRONT: begin
            wr_addr = head_ff - cde_pkg::PTR_W'(1);
            wr_data = data_ff;
         end
         cde_pkg::WR_BACK: begin
            wr_addr = head_ff + cnt_lo;
            wr_data = data_ff;
         end
         cde_pkg::WR_ITER: begin
            wr_addr = head_ff + iter_ff;
            wr_data = rd_data_ff;
         end
         default: begin
            wr_addr = head_ff;
            wr_data = data_ff;
         end
      endcase
   end

   // element store
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // request word and shift iterator
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff  <= req_tdata[cde_pkg::FUNC_W-1:0];
         data_ff  <= req_tdata[cde_pkg::FUNC_W +: cde_pkg::DATA_W];
         index_ff <= req_tdata[cde_pkg::FUNC_W + cde_pkg::DATA_W +: cde_pkg::INDEX_W];
      end
      if (cmd.iter_load) begin
         iter_ff <= cde_pkg::PTR_W'(index_ff);
      end else if (cmd.iter_inc) begin
         iter_ff <= iter_ff + cde_pkg::PTR_W'(1);
      end
   end

   always_comb begin
      head_in = head_ff;
      cnt_in  = cnt_ff;
      if (cmd.clear) begin
         head_in = '0;
         cnt_in  = '0;
      end else begin
         if (cmd.head_dec) head_in = head_ff - cde_pkg::PTR_W'(1);
         if (cmd.head_inc) head_in = head_ff + cde_pkg::PTR_W'(1);
         if (cmd.cnt_inc)  cnt_in  = cnt_ff + cde_pkg::CNT_W'(1);
         if (cmd.cnt_dec)  cnt_in  = cnt_ff - cde_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load)               rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff   <= cmd.rsp_use_rd ? rd_data_ff : '0;
         rsp_status_ff <= cmd.rsp_status;
         rsp_count_ff  <= cnt_ff;
      end
   end

   assign stat.func       = func_ff;
   assign stat.empty      = (cnt_ff == '0);
   assign stat.full       = (cnt_ff == cde_pkg::CNT_W'(cde_pkg::DEPTH));
   assign stat.idx_ok     = ({1'b0, index_ff} < cnt_ff);
   assign stat.shift_more = (iter_next < cnt_ff);
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(cde_pkg::RSP_TDATA_W - cde_pkg::DATA_W - cde_pkg::STATUS_W
                          - cde_pkg::CNT_W){1'b0}},
                        rsp_count_ff, rsp_status_ff, rsp_data_ff};

endmodule

// ----- sv/cde_ctrl.sv -----
// deque controller: sequences each request word over the datapath
// depends on cde_pkg
module cde_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  cde_pkg::cde_stat_type stat,
   output cde_pkg::cde_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_SHRD = 3'd2;
   localparam logic [2:0] S_SHWR = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [cde_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         use_rd_ff, use_rd_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd        = '0;
      cmd.rsp_status = status_ff;
      cmd.rsp_use_rd = use_rd_ff;
      state_in   = state_ff;
      status_in  = status_ff;
      use_rd_in  = use_rd_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               status_in = cde_pkg::ST_OK;
               use_rd_in = 1'b0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            if (stat.func == cde_pkg::FN_PUSH_FRONT || stat.func == cde_pkg::FN_PUSH_BACK) begin
               if (stat.full) begin
                  status_in = cde_pkg::ST_FULL;
               end else begin
                  cmd.wr_en    = 1'b1;
                  cmd.wr_sel   = (stat.func == cde_pkg::FN_PUSH_FRONT) ?
                                 cde_pkg::WR_FRONT : cde_pkg::WR_BACK;
                  cmd.head_dec = (stat.func == cde_pkg::FN_PUSH_FRONT);
                  cmd.cnt_inc  = 1'b1;
               end
            end else if (stat.func inside {cde_pkg::FN_POP_FRONT, cde_pkg::FN_POP_BACK,
                                           cde_pkg::FN_PEEK_FRONT, cde_pkg::FN_PEEK_BACK}) begin
               if (stat.empty) begin
                  status_in = cde_pkg::ST_EMPTY;
               end else begin
                  cmd.rd_en    = 1'b1;
                  cmd.rd_sel   = (stat.func inside {cde_pkg::FN_POP_FRONT,
                                                    cde_pkg::FN_PEEK_FRONT}) ?
                                 cde_pkg::RD_HEAD : cde_pkg::RD_TAIL;
                  cmd.head_inc = (stat.func == cde_pkg::FN_POP_FRONT);
                  cmd.cnt_dec  = (stat.func inside {cde_pkg::FN_POP_FRONT,
                                                    cde_pkg::FN_POP_BACK});
                  use_rd_in    = 1'b1;
               end
            end else if (stat.func == cde_pkg::FN_GET) begin
               if (!stat.idx_ok) begin
                  status_in = cde_pkg::ST_RANGE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = cde_pkg::RD_INDEX;
                  use_rd_in  = 1'b1;
               end
            end else if (stat.func == cde_pkg::FN_REMOVE) begin
               if (!stat.idx_ok) begin
                  status_in = cde_pkg::ST_RANGE;
               end else begin
                  cmd.iter_load = 1'b1;
                  state_in      = S_SHRD;
               end
            end else if (stat.func == cde_pkg::FN_CLEAR) begin
               cmd.clear = 1'b1;
            end
         end
         S_SHRD: begin
            if (stat.shift_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = cde_pkg::RD_NEXT;
               state_in   = S_SHWR;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_SHWR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = cde_pkg::WR_ITER;
            cmd.iter_inc = 1'b1;
            state_in     = S_SHRD;
         end
         S_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= cde_pkg::ST_OK;
         use_rd_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         use_rd_ff <= use_rd_in;
      end
   end

endmodule
